// ----- src/blle_pkg.sv -----
// ----------------------------------------------------------------------------
// blle_pkg
// Types and codes shared by the linked list engine and its checker.
// ----------------------------------------------------------------------------
package blle_pkg;

  localparam int unsigned CNT_W = 7;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_AT   = 3'd5,
    CMD_READ     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_DEL,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] item_value;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
    logic [CNT_W-1:0]   count;
  } out_item_t;

endpackage

// ----- src/bounded_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_linked_list_engine
// Ordered list of signed values held in a node store with next links.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ready_o is high only between commands.
// After a transfer the engine passes through S_RESP alone on an error, an unused
// code or a read out of an empty list, and through S_WALK, S_INS_A and S_RESP on
// a head insert. Any other insert or delete walks the next-link memory one node
// per cycle up to the position (the position is count + 1 for a tail insert and
// count for a tail delete), then updates the links and responds. A read out
// streams one value per cycle from the value and link memories while
// out_ready_i is high. Results pass through a two-entry output buffer; while
// it is full the engine holds its result.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine
  import blle_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_e state_q, state_d;

  logic [IW-1:0]       head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [IW-1:0]       alloc_q;
  logic [IW-1:0]       node_q, node_d;

  logic [IW-1:0]       cur_q, cur_d, prev_q, prev_d, pprev_q, pprev_d;
  logic [CNT_W-1:0]    steps_q, steps_d;
  logic                rd_valid_q, rd_valid_d;
  logic                last_q, last_d;
  logic                is_ins_q, is_ins_d, at_head_q, at_head_d;
  status_e             status_q, status_d;
  logic signed [31:0]  val_q, val_d;

  logic [31:0]         val_mem [CAPACITY];
  logic [IW-1:0]       next_mem [CAPACITY];
  logic [31:0]         val_rdata_q;
  logic [IW-1:0]       next_rdata_q;
  logic                rd_en;
  logic [IW-1:0]       cur_addr;
  logic                val_we, next_we;
  logic [IW-1:0]       val_waddr, next_waddr, next_wdata;

  out_item_t           fifo_q [2];
  logic                wptr_q, rptr_q;
  logic [1:0]          fcnt_q;
  logic                push, pop;
  out_item_t           push_item;

  in_item_t            req;
  logic [CNT_W-1:0]    pe;
  logic [CAPACITY-1:0] free_oh;
  logic [IW-1:0]       alloc_d;
  logic                space;

  assign req      = in_data_i;
  assign cur_addr = rd_valid_q ? next_rdata_q : cur_q;
  assign pop      = out_valid_o && out_ready_i;
  assign space    = (fcnt_q != 2'd2) || pop;

  // lowest free node
  assign free_oh = ~used_q & (used_q + CAPACITY'(1));
  always_comb begin
    alloc_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      alloc_d = alloc_d | (free_oh[i] ? IW'(i) : '0);
    end
  end

  always_comb begin
    unique case (req.command)
      CMD_INS_HEAD, CMD_DEL_HEAD: pe = CNT_W'(1);
      CMD_INS_TAIL:               pe = count_q + CNT_W'(1);
      CMD_DEL_TAIL:               pe = count_q;
      default:                    pe = req.position;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req.command) inside
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
              if (count_q == CAP_CNT || pe == '0 || pe > count_q + CNT_W'(1)) begin
                state_d = S_RESP;
              end else begin
                state_d = S_WALK;
              end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
              if (count_q == '0 || pe == '0 || pe > count_q) begin
                state_d = S_RESP;
              end else begin
                state_d = S_WALK;
              end
            end
            CMD_READ: state_d = (count_q == '0) ? S_RESP : S_READ;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          state_d = is_ins_q ? S_INS_A : S_DEL;
        end
      end
      S_INS_A: state_d = at_head_q ? S_RESP : S_INS_B;
      S_INS_B: state_d = S_RESP;
      S_DEL:   state_d = S_RESP;
      S_READ: begin
        if (steps_q == '0 && !rd_valid_q) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (space) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    used_d     = used_q;
    node_d     = node_q;
    cur_d      = rd_valid_q ? next_rdata_q : cur_q;
    prev_d     = prev_q;
    pprev_d    = pprev_q;
    steps_d    = steps_q;
    rd_valid_d = 1'b0;
    last_d     = last_q;
    is_ins_d   = is_ins_q;
    at_head_d  = at_head_q;
    status_d   = status_q;
    val_d      = val_q;
    rd_en      = 1'b0;
    val_we     = 1'b0;
    next_we    = 1'b0;
    val_waddr  = node_q;
    next_waddr = node_q;
    next_wdata = cur_addr;
    push       = 1'b0;
    push_item  = '{out_value: '0, status: status_q, last: 1'b1, count: count_q};
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cur_d     = head_q;
          val_d     = req.item_value;
          at_head_d = (pe == CNT_W'(1));
          status_d  = ST_OK;
          case (req.command) inside
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
              is_ins_d = 1'b1;
              steps_d  = pe - CNT_W'(1);
              if (count_q == CAP_CNT) begin
                status_d = ST_FULL;
              end else if (pe == '0 || pe > count_q + CNT_W'(1)) begin
                status_d = ST_BOUNDS;
              end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
              is_ins_d = 1'b0;
              steps_d  = pe;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pe == '0 || pe > count_q) begin
                status_d = ST_BOUNDS;
              end
            end
            CMD_READ: begin
              steps_d = count_q;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        node_d = alloc_q;
        if (steps_q != '0) begin
          rd_en      = 1'b1;
          rd_valid_d = 1'b1;
          prev_d     = cur_addr;
          pprev_d    = prev_q;
          steps_d    = steps_q - CNT_W'(1);
        end
      end
      S_INS_A: begin
        val_we     = 1'b1;
        next_we    = 1'b1;
        val_waddr  = node_q;
        next_waddr = node_q;
        next_wdata = cur_addr;
        used_d     = used_q | (CAPACITY'(1) << node_q);
        count_d    = count_q + CNT_W'(1);
        if (at_head_q) begin
          head_d = node_q;
        end
      end
      S_INS_B: begin
        next_we    = 1'b1;
        next_waddr = prev_q;
        next_wdata = node_q;
      end
      S_DEL: begin
        used_d  = used_q & ~(CAPACITY'(1) << prev_q);
        count_d = count_q - CNT_W'(1);
        if (at_head_q) begin
          head_d = cur_addr;
        end else begin
          next_we    = 1'b1;
          next_waddr = pprev_q;
          next_wdata = cur_addr;
        end
      end
      S_READ: begin
        if (rd_valid_q) begin
          push      = 1'b1;
          push_item = '{out_value: val_rdata_q, status: ST_OK, last: last_q,
                        count: count_q};
        end
        if (steps_q != '0 &&
            (2'(fcnt_q + 2'(rd_valid_q)) - 2'(pop)) < 2'd2) begin
          rd_en      = 1'b1;
          rd_valid_d = 1'b1;
          last_d     = (steps_q == CNT_W'(1));
          steps_d    = steps_q - CNT_W'(1);
        end
      end
      S_RESP: begin
        push = space;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      used_q     <= '0;
      alloc_q    <= '0;
      rd_valid_q <= 1'b0;
      steps_q    <= '0;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      fcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      used_q     <= used_d;
      alloc_q    <= alloc_d;
      rd_valid_q <= rd_valid_d;
      steps_q    <= steps_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    pprev_q   <= pprev_d;
    last_q    <= last_d;
    is_ins_q  <= is_ins_d;
    at_head_q <= at_head_d;
    status_q  <= status_d;
    val_q     <= val_d;
    if (push) begin
      fifo_q[wptr_q] <= push_item;
    end
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_q;
    end
    if (rd_en) begin
      val_rdata_q <= val_mem[cur_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (rd_en) begin
      next_rdata_q <= next_mem[cur_addr];
    end
  end

  assign out_valid_o = (fcnt_q != '0);
  assign out_data_o  = fifo_q[rptr_q];

endmodule

// ----- src/blle_checker.sv -----
// ----------------------------------------------------------------------------
// blle_checker
// Port-level checks on the linked list engine, bound to its top level.
// ----------------------------------------------------------------------------
module blle_checker
  import blle_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // a stalled result transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.count <= CAP_CNT)
    else $error("count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.count == CAP_CNT)
    else $error("full status with spare nodes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY
      |-> out_data_o.count == '0 && out_data_o.last)
    else $error("empty status on non-empty list");

endmodule

bind bounded_linked_list_engine blle_checker #(.CAPACITY(CAPACITY)) u_blle_checker (.*);

// ----- tb/sv/blle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blle_scoreboard
// Watches both channels of the linked list engine, keeps its own ordered copy
// of the list, predicts the results of every accepted command and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module blle_scoreboard
  import blle_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        failures_o,
  output int        backlog_o,
  output int        occupancy_o
);

  logic signed [31:0] list_values[$];
  out_item_t          pending_results[$];
  int                 mismatch_count;

  function automatic void queue_result(logic signed [31:0] value, status_e st, logic last);
    out_item_t res;
    res.out_value = value;
    res.status    = st;
    res.last      = last;
    res.count     = CNT_W'(list_values.size());
    pending_results.push_back(res);
  endfunction

  function automatic status_e insert_value(logic signed [31:0] value, int unsigned pos);
    if (list_values.size() >= CAPACITY) return ST_FULL;
    if (pos < 1 || pos > list_values.size() + 1) return ST_BOUNDS;
    list_values.insert(pos - 1, value);
    return ST_OK;
  endfunction

  function automatic status_e remove_value(int unsigned pos);
    if (list_values.size() == 0) return ST_EMPTY;
    if (pos < 1 || pos > list_values.size()) return ST_BOUNDS;
    list_values.delete(pos - 1);
    return ST_OK;
  endfunction

  function automatic void predict_command(in_item_t item);
    status_e st;
    st = ST_OK;
    case (item.command)
      CMD_INS_HEAD: st = insert_value(item.item_value, 1);
      CMD_INS_TAIL: st = insert_value(item.item_value, list_values.size() + 1);
      CMD_INS_AT:   st = insert_value(item.item_value, item.position);
      CMD_DEL_HEAD: st = remove_value(1);
      CMD_DEL_TAIL: st = remove_value(list_values.size());
      CMD_DEL_AT:   st = remove_value(item.position);
      CMD_READ: begin
        if (list_values.size() == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          foreach (list_values[i]) begin
            queue_result(list_values[i], ST_OK, i == list_values.size() - 1);
          end
        end
        return;
      end
      default: st = ST_OK;
    endcase
    queue_result('0, st, 1'b1);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      list_values.delete();
      pending_results.delete();
      mismatch_count = 0;
      failures_o  <= 0;
      backlog_o   <= 0;
      occupancy_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data_i);
        end else begin
          want = pending_results.pop_front();
          check_field("out_value", want.out_value, out_data_i.out_value);
          check_field("status", 32'(want.status), 32'(out_data_i.status));
          check_field("last", 32'(want.last), 32'(out_data_i.last));
          check_field("count", 32'(want.count), 32'(out_data_i.count));
        end
      end
      if (in_valid_i && in_ready_i) predict_command(in_data_i);
      failures_o  <= mismatch_count;
      backlog_o   <= pending_results.size();
      occupancy_o <= list_values.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the linked list engine with random gaps and stalls the
// result channel at random; a directed opening covers the empty, bounds and
// edge-value cases, then random runs fill the store towards full and then mostly delete from it.
// ----------------------------------------------------------------------------
module tb_top;
  import blle_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned FILL_ITEMS   = 84;
  localparam int unsigned EMPTY_ITEMS  = 52;
  localparam int unsigned MAX_IDLE     = 18;
  localparam logic [2:0]  CMD_SPARE    = 3'd7;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic [4:0]  stall_left = '0;
  bit          source_calm;
  int          failures;
  int          backlog;
  int          occupancy;
  int unsigned cycles = 0;

  bounded_linked_list_engine #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  blle_scoreboard #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .failures_o (failures),
    .backlog_o  (backlog),
    .occupancy_o(occupancy)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result sink: a fresh stall is drawn after every transfer
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int unsigned wait_cycles;
    bit          calm;
    if (!rst_ni) begin
      stall_left <= '0;
      out_ready  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 15) == 0) calm = !calm;
        wait_cycles = calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (stall_left != 0) begin
        wait_cycles = stall_left - 1;
      end else begin
        wait_cycles = 0;
      end
      stall_left <= 5'(wait_cycles);
      out_ready  <= (wait_cycles == 0);
    end
  end

  task automatic issue(logic [2:0] cmd, logic signed [31:0] value, logic [6:0] pos);
    int unsigned gap;
    if ($urandom_range(0, 11) == 0) source_calm = !source_calm;
    gap = source_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, item_value: value, position: pos};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic random_item(bit filling);
    int unsigned        r;
    int unsigned        len;
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         pos;
    len = occupancy;
    r   = $urandom_range(0, 99);
    if (filling) begin
      cmd = r < 30 ? CMD_INS_HEAD : r < 60 ? CMD_INS_TAIL : r < 92 ? CMD_INS_AT :
            r < 93 ? CMD_DEL_HEAD : r < 94 ? CMD_DEL_TAIL : r < 95 ? CMD_DEL_AT :
            r < 99 ? CMD_READ : CMD_SPARE;
    end else begin
      cmd = r < 1  ? CMD_INS_HEAD : r < 2  ? CMD_INS_TAIL : r < 3  ? CMD_INS_AT :
            r < 33 ? CMD_DEL_HEAD : r < 63 ? CMD_DEL_TAIL : r < 94 ? CMD_DEL_AT :
            r < 98 ? CMD_READ : CMD_SPARE;
    end
    value = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = '0;
        default: value = '1;
      endcase
    end
    pos = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 9) < 8) begin
      if (cmd == CMD_INS_AT) pos = 7'($urandom_range(1, len + 1));
      else if (cmd == CMD_DEL_AT) pos = (len == 0) ? 7'd1 : 7'($urandom_range(1, len));
    end
    issue(cmd, value, pos);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list
    issue(CMD_READ,     '0, '0);
    issue(CMD_DEL_HEAD, '0, '0);
    issue(CMD_DEL_TAIL, '0, '0);
    issue(CMD_DEL_AT,   '0, 7'd127);
    issue(CMD_INS_AT,   32'sd5, 7'd0);
    issue(CMD_INS_AT,   32'sd6, 7'd2);
    // edge values and positions
    issue(CMD_INS_HEAD, 32'sh8000_0000, 7'd127);
    issue(CMD_INS_TAIL, 32'sh7fff_ffff, '0);
    issue(CMD_INS_AT,   '1, 7'd2);
    issue(CMD_INS_AT,   '0, 7'd4);
    issue(CMD_INS_AT,   32'sd7, 7'd6);
    issue(CMD_INS_AT,   32'sd8, 7'd127);
    issue(CMD_READ,     '1, 7'd127);
    issue(CMD_DEL_AT,   '0, 7'd0);
    issue(CMD_DEL_AT,   '0, 7'd5);
    issue(CMD_DEL_AT,   '0, 7'd127);
    issue(CMD_DEL_AT,   '0, 7'd2);
    issue(CMD_SPARE,    32'sh5a5a_a5a5, 7'd85);
    issue(CMD_DEL_TAIL, '0, '0);
    issue(CMD_DEL_HEAD, '0, '0);
    issue(CMD_READ,     '0, '0);
    issue(CMD_INS_HEAD, 32'sh5555_5555, 7'd42);
    issue(CMD_DEL_AT,   '0, 7'd1);
    issue(CMD_READ,     '0, '0);

    for (int n = 0; n < FILL_ITEMS + EMPTY_ITEMS; n++) random_item(n < FILL_ITEMS);
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/blle_pkg.sv
src/bounded_linked_list_engine.sv
src/blle_checker.sv
tb/sv/blle_checker.sv
tb/sv/tb_top.sv
